[rtl/ast_pkg.sv]
package ast_pkg;

    localparam int unsigned ADDR_W = 4;

    localparam logic [1:0] REG_GAIN     = 2'd0;
    localparam logic [1:0] REG_MAX_STEP = 2'd1;
    localparam logic [1:0] REG_MIN_STEP = 2'd2;

    localparam logic [16:0] GAIN_RESET     = 17'd6554;
    localparam logic [14:0] MAX_STEP_RESET = 15'd1280;
    localparam logic [14:0] MIN_STEP_RESET = 15'd13;

    localparam logic signed [17:0] FULL_TURN = 18'sd46080;
    localparam logic signed [17:0] HALF_TURN = 18'sd23040;

    typedef struct packed {
        logic [16:0] gain;
        logic [14:0] max_step;
        logic [14:0] min_step;
    } cfg_t;

    typedef struct packed {
        logic [15:0]        new_angle;
        logic signed [15:0] applied_step;
        logic signed [15:0] wrapped_error;
    } res_t;

endpackage

[rtl/ast_in_if.sv]
interface ast_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] target_angle;

    modport source (output valid, output target_angle, input ready);
    modport sink (input valid, input target_angle, output ready);
endinterface

[rtl/ast_out_if.sv]
interface ast_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        new_angle;
    logic signed [15:0] applied_step;
    logic signed [15:0] wrapped_error;

    modport source (output valid, output new_angle, output applied_step,
                    output wrapped_error, input ready);
    modport sink (input valid, input new_angle, input applied_step,
                  input wrapped_error, output ready);
endinterface

[rtl/ast_cfg_regs.sv]
module ast_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ast_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output ast_pkg::cfg_t             cfg
);

    ast_pkg::cfg_t cfg_reg;
    ast_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                ast_pkg::REG_GAIN:     cfg_next.gain     = pwdata[16:0];
                ast_pkg::REG_MAX_STEP: cfg_next.max_step = pwdata[14:0];
                ast_pkg::REG_MIN_STEP: cfg_next.min_step = pwdata[14:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain     <= ast_pkg::GAIN_RESET;
            cfg_reg.max_step <= ast_pkg::MAX_STEP_RESET;
            cfg_reg.min_step <= ast_pkg::MIN_STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            ast_pkg::REG_GAIN:     prdata = {15'd0, cfg_reg.gain};
            ast_pkg::REG_MAX_STEP: prdata = {17'd0, cfg_reg.max_step};
            ast_pkg::REG_MIN_STEP: prdata = {17'd0, cfg_reg.min_step};
            default:               prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[rtl/ast_step_calc.sv]
module ast_step_calc (
    input  logic [15:0]   cur_angle,
    input  logic [15:0]   target_angle,
    input  ast_pkg::cfg_t cfg,
    output ast_pkg::res_t res
);

    logic signed [17:0] diff;
    logic signed [17:0] err18;
    logic signed [15:0] err16;
    logic signed [17:0] gain_s;
    logic signed [33:0] prod;
    logic signed [17:0] scaled;
    logic signed [17:0] mn_s;
    logic signed [17:0] mx_s;
    logic signed [17:0] clamped;
    logic               big;
    logic signed [17:0] step;
    logic signed [17:0] delta;
    logic signed [17:0] sum;
    logic signed [17:0] wrapped;

    assign diff = $signed({2'b00, target_angle}) - $signed({2'b00, cur_angle});

    // The difference never exceeds one and a half turns, so one correction suffices.
    always_comb
    begin
        if (diff > ast_pkg::HALF_TURN)
        begin
            err18 = diff - ast_pkg::FULL_TURN;
        end
        else if (diff < -ast_pkg::HALF_TURN)
        begin
            err18 = diff + ast_pkg::FULL_TURN;
        end
        else
        begin
            err18 = diff;
        end
    end

    assign err16  = err18[15:0];
    assign gain_s = $signed({1'b0, cfg.gain});
    assign prod   = err16 * gain_s;
    assign scaled = prod[33:16];

    assign mn_s = $signed({3'b000, cfg.min_step});
    assign mx_s = $signed({3'b000, cfg.max_step});
    assign big  = (scaled >= mn_s) || (scaled <= -mn_s);

    always_comb
    begin
        if (scaled > mx_s)
        begin
            clamped = mx_s;
        end
        else if (scaled < -mx_s)
        begin
            clamped = -mx_s;
        end
        else
        begin
            clamped = scaled;
        end
    end

    // A small step lands exactly on the target when it would otherwise overshoot.
    always_comb
    begin
        step  = '0;
        delta = '0;
        if (err18 != 18'sd0)
        begin
            if (big)
            begin
                step  = clamped;
                delta = clamped;
            end
            else if (err18 > 18'sd0)
            begin
                step  = mn_s;
                delta = (err18 <= mn_s) ? err18 : mn_s;
            end
            else
            begin
                step  = -mn_s;
                delta = (-err18 <= mn_s) ? err18 : -mn_s;
            end
        end
    end

    assign sum = $signed({2'b00, cur_angle}) + delta;

    always_comb
    begin
        if (sum < 18'sd0)
        begin
            wrapped = sum + ast_pkg::FULL_TURN;
        end
        else if (sum >= ast_pkg::FULL_TURN)
        begin
            wrapped = sum - ast_pkg::FULL_TURN;
        end
        else
        begin
            wrapped = sum;
        end
    end

    assign res.new_angle     = wrapped[15:0];
    assign res.applied_step  = step[15:0];
    assign res.wrapped_error = err16;

endmodule

[rtl/angle_slew_tracker_top.sv]
// An input item is held in the input register, its result in the result register.
// Throughput: one item per cycle while the result register is not stalled; the
// heading update, including its single multiply, is combinational between them.
// A stalled result register holds the input register, which then holds the input.
// Reset (rst_n, asynchronous, active low) clears the heading to zero, empties both
// registers and restores the gain, maximum step and minimum step defaults.
module angle_slew_tracker_top (
    input  logic                       clk,
    input  logic                       rst_n,
    ast_in_if.sink                     sample_in,
    ast_out_if.source                  result_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ast_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    ast_pkg::cfg_t cfg;
    ast_pkg::res_t calc_res;

    logic          stage_valid_reg;
    logic          stage_valid_next;
    logic [15:0]   target_reg;
    logic [15:0]   target_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    ast_pkg::res_t res_reg;
    ast_pkg::res_t res_next;
    logic [15:0]   cur_reg;
    logic [15:0]   cur_next;
    logic          advance;
    logic          in_take;

    ast_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ast_step_calc u_calc (
        .cur_angle    (cur_reg),
        .target_angle (target_reg),
        .cfg          (cfg),
        .res          (calc_res)
    );

    assign advance         = stage_valid_reg && (!out_valid_reg || result_out.ready);
    assign sample_in.ready = !stage_valid_reg || advance;
    assign in_take         = sample_in.valid && sample_in.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        target_next      = target_reg;
        out_valid_next   = out_valid_reg;
        res_next         = res_reg;
        cur_next         = cur_reg;
        if (advance)
        begin
            stage_valid_next = 1'b0;
            out_valid_next   = 1'b1;
            res_next         = calc_res;
            cur_next         = calc_res.new_angle;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_take)
        begin
            stage_valid_next = 1'b1;
            target_next      = sample_in.target_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            cur_reg         <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            cur_reg         <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        res_reg    <= res_next;
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.new_angle     = res_reg.new_angle;
    assign result_out.applied_step  = res_reg.applied_step;
    assign result_out.wrapped_error = res_reg.wrapped_error;

    a_heading_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg < 16'd46080)
        else $error("Stored heading has left the range of one turn.");

    a_result_matches_heading: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.new_angle == cur_reg))
        else $error("Presented heading differs from the stored heading.");

    a_step_follows_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((res_reg.applied_step == 16'sd0)
                           || ((res_reg.applied_step > 16'sd0)
                               == (res_reg.wrapped_error > 16'sd0))))
        else $error("Step moves away from the target.");

    a_error_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((res_reg.wrapped_error <= 16'sd23040)
                           && (res_reg.wrapped_error >= -16'sd23040)))
        else $error("Error lies outside half a turn.");

endmodule

[bench/angle_slew_tracker_top_tb.sv]
module angle_slew_tracker_top_tb;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int LONG_HOLD       = 60;
    localparam int SETTLE_CYCLES   = 4;
    localparam int PRINT_LIMIT     = 50;
    localparam int DIRECTED_COUNT  = 26;

    typedef enum logic [1:0] {ROW_KNOWN, ROW_PREDICT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [15:0]   target;
        logic [16:0]   gain;
        logic [14:0]   max_step;
        logic [14:0]   min_step;
        ast_pkg::res_t want;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        '{ROW_KNOWN,   16'd0,     17'd0, 15'd0, 15'd0, '{16'd0, 16'sd0, 16'sd0}},
        '{ROW_KNOWN,   16'd23040, 17'd0, 15'd0, 15'd0, '{16'd1280, 16'sd1280, 16'sd23040}},
        '{ROW_PREDICT, 16'd46079, 17'd0, 15'd0, 15'd0, '0},
        '{ROW_PREDICT, 16'd65535, 17'd0, 15'd0, 15'd0, '0},
        '{ROW_PREDICT, 16'd12,    17'd0, 15'd0, 15'd0, '0},
        '{ROW_CFG,     16'd0, 17'd65536, 15'd23040, 15'd0, '0},
        '{ROW_PREDICT, 16'd0,     17'd0, 15'd0, 15'd0, '0},
        '{ROW_KNOWN,   16'd23040, 17'd0, 15'd0, 15'd0, '{16'd23040, 16'sd23040, 16'sd23040}},
        '{ROW_KNOWN,   16'd0,     17'd0, 15'd0, 15'd0, '{16'd0, -16'sd23040, -16'sd23040}},
        '{ROW_KNOWN,   16'd65535, 17'd0, 15'd0, 15'd0, '{16'd19455, 16'sd19455, 16'sd19455}},
        '{ROW_KNOWN,   16'd46079, 17'd0, 15'd0, 15'd0, '{16'd46079, -16'sd19456, -16'sd19456}},
        '{ROW_KNOWN,   16'd0,     17'd0, 15'd0, 15'd0, '{16'd0, 16'sd1, 16'sd1}},
        '{ROW_CFG,     16'd0, 17'd0, 15'd0, 15'd32767, '0},
        '{ROW_KNOWN,   16'd100,   17'd0, 15'd0, 15'd0, '{16'd100, 16'sd32767, 16'sd100}},
        '{ROW_KNOWN,   16'd46000, 17'd0, 15'd0, 15'd0, '{16'd46000, -16'sd32767, -16'sd180}},
        '{ROW_CFG,     16'd0, 17'd0, 15'd0, 15'd0, '0},
        '{ROW_KNOWN,   16'd5,     17'd0, 15'd0, 15'd0, '{16'd46000, 16'sd0, 16'sd85}},
        '{ROW_CFG,     16'd0, 17'd131071, 15'd32767, 15'd13, '0},
        '{ROW_KNOWN,   16'd23040, 17'd0, 15'd0, 15'd0, '{16'd13233, -16'sd32767, -16'sd22960}},
        '{ROW_CFG,     16'd0, 17'd6554, 15'd1280, 15'd13, '0},
        '{ROW_KNOWN,   16'd13253, 17'd0, 15'd0, 15'd0, '{16'd13246, 16'sd13, 16'sd20}},
        '{ROW_KNOWN,   16'd13241, 17'd0, 15'd0, 15'd0, '{16'd13241, -16'sd13, -16'sd5}},
        '{ROW_KNOWN,   16'd13211, 17'd0, 15'd0, 15'd0, '{16'd13228, -16'sd13, -16'sd30}},
        '{ROW_KNOWN,   16'd13228, 17'd0, 15'd0, 15'd0, '{16'd13228, 16'sd0, 16'sd0}},
        '{ROW_KNOWN,   16'd13358, 17'd0, 15'd0, 15'd0, '{16'd13241, 16'sd13, 16'sd130}},
        '{ROW_PREDICT, 16'd13111, 17'd0, 15'd0, 15'd0, '0}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ast_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    ast_in_if  sample_if ();
    ast_out_if result_if ();

    angle_slew_tracker_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_if),
        .result_out (result_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    ast_pkg::res_t heading_q [$];
    logic [15:0]   tracked_heading;
    ast_pkg::cfg_t tracking_cfg;
    bit            calm;
    bit            long_hold_req;
    int            mismatches;
    int            items_sent;
    int            results_seen;
    int            cfg_loads;
    int            long_holds;

    initial clk = 1'b0;

    always #5 clk = ~clk;

    function automatic ast_pkg::res_t next_heading(input logic [15:0] tgt,
                                                   input logic [15:0] hdg,
                                                   input ast_pkg::cfg_t c);
        ast_pkg::res_t r;
        longint        err;
        longint        scaled;
        longint        step;
        longint        new_hdg;
        longint        lim;
        longint        floor_mn;
        err      = longint'(tgt) - longint'(hdg);
        lim      = longint'(c.max_step);
        floor_mn = longint'(c.min_step);
        while (err > longint'(ast_pkg::HALF_TURN))
            err -= longint'(ast_pkg::FULL_TURN);
        while (err < -longint'(ast_pkg::HALF_TURN))
            err += longint'(ast_pkg::FULL_TURN);
        step    = 0;
        new_hdg = longint'(hdg);
        if (err != 0)
        begin
            scaled = (err * longint'(c.gain)) >>> 16;
            if (scaled >= floor_mn || scaled <= -floor_mn)
            begin
                if (scaled > lim)
                    scaled = lim;
                else if (scaled < -lim)
                    scaled = -lim;
                step    = scaled;
                new_hdg = new_hdg + scaled;
            end
            else if (err > 0)
            begin
                step    = floor_mn;
                new_hdg = (err <= floor_mn) ? new_hdg + err : new_hdg + floor_mn;
            end
            else
            begin
                step    = -floor_mn;
                new_hdg = (-err <= floor_mn) ? new_hdg + err : new_hdg - floor_mn;
            end
        end
        new_hdg = new_hdg % longint'(ast_pkg::FULL_TURN);
        if (new_hdg < 0)
            new_hdg += longint'(ast_pkg::FULL_TURN);
        r.new_angle     = new_hdg[15:0];
        r.applied_step  = step[15:0];
        r.wrapped_error = err[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch on %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
    endtask

    task automatic cfg_access(input logic wr, input logic [1:0] idx, input logic [31:0] data,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        penable <= 1'b0;
    endtask

    task automatic load_tracking(input logic [16:0] g, input logic [14:0] mx,
                                 input logic [14:0] mn);
        logic [31:0] rd;
        cfg_access(1'b1, ast_pkg::REG_GAIN, {15'd0, g}, rd);
        cfg_access(1'b1, ast_pkg::REG_MAX_STEP, {17'd0, mx}, rd);
        cfg_access(1'b1, ast_pkg::REG_MIN_STEP, {17'd0, mn}, rd);
        cfg_access(1'b0, ast_pkg::REG_GAIN, 32'd0, rd);
        if (rd[16:0] !== g)
            report_mismatch("gain readback", int'(rd[16:0]), int'(g));
        cfg_access(1'b0, ast_pkg::REG_MAX_STEP, 32'd0, rd);
        if (rd[14:0] !== mx)
            report_mismatch("max_step readback", int'(rd[14:0]), int'(mx));
        cfg_access(1'b0, ast_pkg::REG_MIN_STEP, 32'd0, rd);
        if (rd[14:0] !== mn)
            report_mismatch("min_step readback", int'(rd[14:0]), int'(mn));
        psel   <= 1'b0;
        pwrite <= 1'b0;
        tracking_cfg = '{g, mx, mn};
        cfg_loads++;
    endtask

    task automatic settle();
        sample_if.valid <= 1'b0;
        while (heading_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic offer_target(input logic [15:0] tgt, input bit known,
                                input ast_pkg::res_t known_res);
        ast_pkg::res_t predicted;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        sample_if.valid        <= 1'b1;
        sample_if.target_angle <= tgt;
        // The transfer takes place at the first edge that finds ready high.
        do
            @(posedge clk);
        while (!sample_if.ready);
        predicted       = next_heading(tgt, tracked_heading, tracking_cfg);
        tracked_heading = predicted.new_angle;
        heading_q.push_back(known ? known_res : predicted);
        items_sent++;
    endtask

    always @(posedge clk)
    begin : result_check
        ast_pkg::res_t want;
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            results_seen++;
            if (heading_q.size() == 0)
                report_mismatch("transfer with no result outstanding, new_angle",
                                int'(result_if.new_angle), -1);
            else
            begin
                want = heading_q.pop_front();
                if (result_if.new_angle !== want.new_angle)
                    report_mismatch("new_angle", int'(result_if.new_angle),
                                    int'(want.new_angle));
                if (result_if.applied_step !== want.applied_step)
                    report_mismatch("applied_step", int'(result_if.applied_step),
                                    int'(want.applied_step));
                if (result_if.wrapped_error !== want.wrapped_error)
                    report_mismatch("wrapped_error", int'(result_if.wrapped_error),
                                    int'(want.wrapped_error));
            end
        end
    end

    initial
    begin : result_sink
        int hold;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_if.ready <= 1'b0;
                for (hold = 0; hold < LONG_HOLD; hold++)
                    @(posedge clk);
                long_holds++;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int            i;
        int            p;
        int            k;
        int            sel;
        int            tv;
        int            last_target;
        int            span;
        logic [16:0]   g;
        logic [14:0]   mx;
        logic [14:0]   mn;
        ast_pkg::res_t no_res;
        rst_n                  <= 1'b0;
        sample_if.valid        <= 1'b0;
        sample_if.target_angle <= 16'd0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= 32'd0;
        no_res          = '0;
        last_target     = 0;
        tracked_heading = 16'd0;
        tracking_cfg    = '{ast_pkg::GAIN_RESET, ast_pkg::MAX_STEP_RESET,
                            ast_pkg::MIN_STEP_RESET};
        calm            = 1'b0;
        long_hold_req   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_COUNT; i++)
        begin
            case (DIRECTED_ROWS[i].kind)
                ROW_CFG:
                begin
                    settle();
                    load_tracking(DIRECTED_ROWS[i].gain, DIRECTED_ROWS[i].max_step,
                                  DIRECTED_ROWS[i].min_step);
                end
                ROW_KNOWN:
                    offer_target(DIRECTED_ROWS[i].target, 1'b1, DIRECTED_ROWS[i].want);
                default:
                    offer_target(DIRECTED_ROWS[i].target, 1'b0, no_res);
            endcase
        end

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            if (p == 0)
                load_tracking(ast_pkg::GAIN_RESET, ast_pkg::MAX_STEP_RESET,
                              ast_pkg::MIN_STEP_RESET);
            else
            begin
                case ($urandom_range(0, 5))
                    0:       g = 17'd0;
                    1:       g = 17'd65536;
                    2:       g = 17'd131071;
                    3:       g = 17'($urandom_range(0, 131071));
                    default: g = 17'($urandom_range(1000, 20000));
                endcase
                case ($urandom_range(0, 5))
                    0:       mx = 15'd0;
                    1:       mx = 15'd23040;
                    2:       mx = 15'd32767;
                    3:       mx = 15'($urandom_range(0, 32767));
                    default: mx = 15'($urandom_range(16, 2000));
                endcase
                case ($urandom_range(0, 5))
                    0:       mn = 15'd0;
                    1:       mn = 15'd23040;
                    2:       mn = 15'd32767;
                    3:       mn = 15'($urandom_range(0, 32767));
                    default: mn = 15'($urandom_range(0, 64));
                endcase
                load_tracking(g, mx, mn);
            end
            calm = (p == PHASES - 1);
            if (p == 2)
                long_hold_req = 1'b1;
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (p == 4 && k == ITEMS_PER_PHASE / 2)
                    settle();
                sel  = $urandom_range(0, 9);
                span = (tracking_cfg.min_step > 100) ? 100 : int'(tracking_cfg.min_step);
                case (sel)
                    0, 1, 2: tv = last_target;
                    3, 4:    tv = int'(tracked_heading) + int'($urandom_range(0, 400)) - 200;
                    5:       tv = int'($urandom_range(0, 46079));
                    6:       tv = int'($urandom_range(0, 65535));
                    7:       tv = int'(tracked_heading);
                    8:       tv = int'(tracked_heading) + ($urandom_range(0, 1) ? 23040 : -23040);
                    default: tv = int'(tracked_heading) + int'($urandom_range(0, 2 * span + 2))
                                  - (span + 1);
                endcase
                if (tv < 0)
                    tv += 46080;
                if (tv > 65535)
                    tv -= 46080;
                last_target = tv;
                offer_target(16'(tv), 1'b0, no_res);
            end
        end
        settle();

        $display("Tracked %0d heading samples (%0d from the directed table) over %0d %s",
                 items_sent, DIRECTED_COUNT - 5, cfg_loads, "register loads.");
        $display("Checked %0d results, with %0d long receiver hold-off(s); %0d mismatch(es).",
                 results_seen, long_holds, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
